### sv/adpd_pkg.sv
// ----------------------------------------------------------------------------
// adpd_pkg: shared types and constants for the ADPCM packet decoder
// Widths of the stream fields, the coefficient bank size, and the operand
// bundle that the top level hands to the sample predictor.
// ----------------------------------------------------------------------------
package adpd_pkg;

    localparam int unsigned COEF_COUNT              = 8;
    localparam int unsigned COEF_ADDR_W             = 3;
    localparam int unsigned CFG_DATA_W              = 32;
    localparam int unsigned PCM_W                   = 16;
    localparam int unsigned RUN_W                   = 16;
    localparam int unsigned BYTE_W                  = 8;
    localparam int unsigned NIB_W                   = 4;
    localparam int unsigned SCALE_W                 = 4;
    localparam int unsigned PRED_W                  = 3;
    localparam int unsigned POS_W                   = 3;
    localparam int unsigned COEF_SHIFT              = 11;
    localparam int unsigned DEFAULT_MAX_RUN_SAMPLES = 65535;

    // Nibbles of the held data byte that still have to be decoded.
    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_LOW,
        PEND_BOTH
    } pend_t;

    typedef struct packed {
        logic signed [PCM_W-1:0] coef_newest;
        logic signed [PCM_W-1:0] coef_older;
        logic signed [PCM_W-1:0] newest;
        logic signed [PCM_W-1:0] older;
        logic        [NIB_W-1:0] nibble;
        logic        [SCALE_W-1:0] scale;
    } predict_in_t;

endpackage

### sv/adpd_predict.sv
// ----------------------------------------------------------------------------
// adpd_predict: one ADPCM sample
// Second-order prediction from the two history samples, floor shift by the
// coefficient fraction, plus the scaled nibble, saturated to 16 bits.
// ----------------------------------------------------------------------------
module adpd_predict
    import adpd_pkg::*;
(
    input  predict_in_t             pin,
    output logic signed [PCM_W-1:0] sample
);

    localparam int unsigned PROD_W = 2 * PCM_W;
    localparam int unsigned SUM_W  = PROD_W + 1;
    localparam int unsigned PRED_SUM_W = SUM_W - COEF_SHIFT;
    localparam int unsigned STEP_W = NIB_W + (1 << SCALE_W) - 1;
    localparam int unsigned TOT_W  = PRED_SUM_W + 1;

    logic signed [PROD_W-1:0]     prod_newest;
    logic signed [PROD_W-1:0]     prod_older;
    logic signed [SUM_W-1:0]      prod_sum;
    logic signed [PRED_SUM_W-1:0] pred;
    logic signed [STEP_W-1:0]     step;
    logic signed [TOT_W-1:0]      total;

    always_comb begin
        prod_newest = pin.coef_newest * pin.newest;
        prod_older  = pin.coef_older * pin.older;
        prod_sum    = SUM_W'(prod_newest) + SUM_W'(prod_older);
        // Dropping the low bits of a two's complement value is a floor shift.
        pred        = prod_sum[SUM_W-1:COEF_SHIFT];
        step        = STEP_W'($signed(pin.nibble)) <<< pin.scale;
        total       = TOT_W'(pred) + TOT_W'(step);
        if (total[TOT_W-1:PCM_W-1] == '0 || total[TOT_W-1:PCM_W-1] == '1) begin
            sample = total[PCM_W-1:0];
        end else if (total[TOT_W-1]) begin
            sample = {1'b1, {(PCM_W-1){1'b0}}};
        end else begin
            sample = {1'b0, {(PCM_W-1){1'b1}}};
        end
    end

endmodule

### sv/adpcm_packet_decoder.sv
// ----------------------------------------------------------------------------
// adpcm_packet_decoder: single-channel 4-bit ADPCM packet decoder
// Parses header bytes, decodes two nibbles per data byte into saturated
// 16-bit PCM samples and stops after the loaded sample count of a run.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                         handshake
//  s_       in   tdata: byte, start_newest, start_older, count   tvalid/tready
//                tuser: run_start
//  m_       out  tdata: pcm_sample, tlast: run_done              tvalid/tready
//  cfg_     in   coefficient pair per predictor                  cfg_wr_en only
//
//  A data byte is held until each sample it produces is issued; a header or
//  ignored byte is not held. The loop through the history registers and the
//  predictor sets one sample per cycle while the output is not stalled. The
//  next byte is taken in the cycle its predecessor's last sample moves into
//  the output register, except when a run ends on a high nibble, where it is
//  taken in the cycle after. Synchronous reset clears coefficients and all
//  state but the held byte, tdata and tlast. A stall holds pending nibbles.
// ----------------------------------------------------------------------------
module adpcm_packet_decoder
    import adpd_pkg::*;
#(
    parameter int unsigned MAX_RUN_SAMPLES = DEFAULT_MAX_RUN_SAMPLES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [7:0] data_byte, [23:8] start_newest, [39:24] start_older,
    // [55:40] run_samples
    input  logic [55:0]            s_tdata,
    // [0] run_start
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [15:0] pcm_sample
    output logic [15:0]            m_tdata,
    output logic                   m_tlast,
    input  logic                   cfg_wr_en,
    input  logic [COEF_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    localparam int unsigned CNT_W = $clog2(MAX_RUN_SAMPLES + 1);
    localparam int unsigned CMP_W = (CNT_W > RUN_W) ? CNT_W : RUN_W;

    logic [CFG_DATA_W-1:0] coef_reg [COEF_COUNT];

    pend_t                   pend_reg, pend_next;
    logic [BYTE_W-1:0]       data_reg, data_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [PRED_W-1:0]       pred_reg, pred_next;
    logic [SCALE_W-1:0]      scale_reg, scale_next;
    logic signed [PCM_W-1:0] newest_reg, newest_next;
    logic signed [PCM_W-1:0] older_reg, older_next;
    logic [CNT_W-1:0]        remain_reg, remain_next;
    logic                    m_tvalid_reg;
    logic [PCM_W-1:0]        m_tdata_reg;
    logic                    m_tlast_reg;

    logic [BYTE_W-1:0]       in_byte;
    logic signed [PCM_W-1:0] in_newest;
    logic signed [PCM_W-1:0] in_older;
    logic [RUN_W-1:0]        in_count;
    logic [CMP_W-1:0]        count_ext;
    logic [CNT_W-1:0]        count_load;
    logic [CNT_W-1:0]        remain_dec;
    logic [CNT_W-1:0]        eff_remain;
    logic [POS_W-1:0]        eff_pos;
    logic                    fire;
    logic                    accept;
    predict_in_t             pin;
    logic signed [PCM_W-1:0] sample;

    assign in_byte   = s_tdata[7:0];
    assign in_newest = s_tdata[23:8];
    assign in_older  = s_tdata[39:24];
    assign in_count  = s_tdata[55:40];
    assign count_ext = CMP_W'(in_count);
    assign count_load = (count_ext > CMP_W'(MAX_RUN_SAMPLES)) ?
                        CNT_W'(MAX_RUN_SAMPLES) : CNT_W'(count_ext);

    // A sample is produced whenever a nibble is pending and the output
    // register is free or being emptied in this cycle.
    assign fire       = (pend_reg != PEND_NONE) && (!m_tvalid_reg || m_tready);
    assign s_tready   = (pend_reg == PEND_NONE) || ((pend_reg == PEND_LOW) && fire);
    assign accept     = s_tvalid && s_tready;
    assign remain_dec = remain_reg - CNT_W'(1);

    assign pin.coef_newest = coef_reg[pred_reg][31:16];
    assign pin.coef_older  = coef_reg[pred_reg][15:0];
    assign pin.newest      = newest_reg;
    assign pin.older       = older_reg;
    assign pin.nibble      = (pend_reg == PEND_BOTH) ? data_reg[7:4] : data_reg[3:0];
    assign pin.scale       = scale_reg;

    adpd_predict u_predict (
        .pin    (pin),
        .sample (sample)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < COEF_COUNT; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            coef_reg[cfg_addr] <= cfg_wr_data;
        end
    end

    always_comb begin
        pend_next   = pend_reg;
        data_next   = data_reg;
        pos_next    = pos_reg;
        pred_next   = pred_reg;
        scale_next  = scale_reg;
        newest_next = newest_reg;
        older_next  = older_reg;
        remain_next = remain_reg;
        eff_remain  = remain_reg;
        eff_pos     = pos_reg;

        if (fire) begin
            older_next  = newest_reg;
            newest_next = sample;
            remain_next = remain_dec;
            eff_remain  = remain_dec;
            unique case (pend_reg)
                PEND_BOTH: pend_next = (remain_dec == '0) ? PEND_NONE : PEND_LOW;
                PEND_LOW:  pend_next = PEND_NONE;
                default:   pend_next = PEND_NONE;
            endcase
        end

        if (accept) begin
            if (s_tuser) begin
                newest_next = in_newest;
                older_next  = in_older;
                remain_next = count_load;
                pos_next    = '0;
                eff_remain  = count_load;
                eff_pos     = '0;
            end
            // With no run active the byte is dropped without a trace.
            if (eff_remain != '0) begin
                if (eff_pos == '0) begin
                    pred_next  = in_byte[6:4];
                    scale_next = in_byte[3:0];
                    pos_next   = POS_W'(1);
                end else begin
                    data_next = in_byte;
                    pend_next = PEND_BOTH;
                    pos_next  = eff_pos + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg   <= PEND_NONE;
            pos_reg    <= '0;
            pred_reg   <= '0;
            scale_reg  <= '0;
            newest_reg <= '0;
            older_reg  <= '0;
            remain_reg <= '0;
        end else begin
            pend_reg   <= pend_next;
            pos_reg    <= pos_next;
            pred_reg   <= pred_next;
            scale_reg  <= scale_next;
            newest_reg <= newest_next;
            older_reg  <= older_next;
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_tdata_reg <= sample;
            m_tlast_reg <= (remain_reg == CNT_W'(1));
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // A pending nibble always has a sample left to produce.
    a_pend_has_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg != PEND_NONE) |-> (remain_reg != '0))
        else $error("nibble pending with no samples remaining");

    // The held byte is never overwritten while both nibbles are outstanding.
    a_no_accept_both: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg == PEND_BOTH) |-> !s_tready)
        else $error("input taken while a data byte is still undecoded");

    // The final sample of a run leaves nothing pending unless a new byte came in.
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && (remain_reg == CNT_W'(1)) && !accept) |=> (pend_reg == PEND_NONE))
        else $error("nibble still pending after the final sample of a run");

    // A sample marked as the end of a run empties the count unless a new run starts with it.
    a_done_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && (remain_reg == CNT_W'(1)) && !(accept && s_tuser))
            |=> (remain_reg == '0))
        else $error("count not exhausted after the final sample");

endmodule
